### rtl/core/led_bar_level_meter_defines.svh
// ---------------------------------------------------------------------------
// led_bar_level_meter_defines
// Assertion macros shared by the level meter RTL.
// ---------------------------------------------------------------------------
`ifndef LED_BAR_LEVEL_METER_DEFINES_SVH
`define LED_BAR_LEVEL_METER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LBM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lbm_pkg.sv
// ---------------------------------------------------------------------------
// lbm_pkg
// Types and constants of the LED bar level meter.
// ---------------------------------------------------------------------------
package lbm_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	typedef logic signed [8:0] level_t;
	typedef logic        [8:0] decay_timer_t;
	typedef logic        [9:0] hold_count_t;

	localparam level_t LEVEL_FLOOR = -9'sd144;
	localparam level_t LEVEL_CEIL  = 9'sd127;

	// Highest timer value reachable: interval is at most 255, timer clears once past it
	localparam decay_timer_t DECAY_TIMER_MAX = 9'd256;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DECAY_STEP     = 3'd0,
		CFG_DECAY_INTERVAL = 3'd1,
		CFG_HOLD_LENGTH    = 3'd2,
		CFG_PEAK_HOLD_EN   = 3'd3,
		CFG_SINGLE_LIGHT   = 3'd4,
		CFG_LED_COUNT      = 3'd5
	} cfg_reg_t;

	localparam logic [3:0] RST_DECAY_STEP     = 4'd4;
	localparam logic [7:0] RST_DECAY_INTERVAL = 8'd2;
	localparam logic [9:0] RST_HOLD_LENGTH    = 10'd64;
	localparam logic       RST_PEAK_HOLD_EN   = 1'b0;
	localparam logic       RST_SINGLE_LIGHT   = 1'b0;
	localparam logic [4:0] RST_LED_COUNT      = 5'd8;

endpackage

### rtl/core/led_bar_level_meter.sv
// Path: input register, then result register; one level per cycle unless results stall.
// The input register doubles as skid stage, so a level is taken while a result waits.
// Throughput is set by the single compare/update pass between input and result registers.
// Reset (arst_n low, asynchronous): levels, timer and countdown clear to 0,
// configuration returns to step 4, interval 2, hold 64, peak hold off, bar mode, 8 LEDs.
// ---------------------------------------------------------------------------
// led_bar_level_meter
// LED bar peak meter with decay and peak hold; one result per level tick.
// ---------------------------------------------------------------------------
`include "led_bar_level_meter_defines.svh"

module led_bar_level_meter #(
	parameter int MAX_LEDS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [lbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lbm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// level channel
	input  logic                                level_valid,
	output logic                                level_stall,
	input  lbm_pkg::level_t                     level_db,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [MAX_LEDS-1:0]                 led_mask,
	output lbm_pkg::level_t                     shown_level
);
	import lbm_pkg::*;

	// configuration registers
	logic [3:0] decay_step_q;
	logic [7:0] decay_interval_q;
	logic [9:0] hold_length_q;
	logic       peak_hold_en_q;
	logic       single_light_q;
	logic [4:0] led_count_q;

	// meter state
	level_t       display_level_q;
	decay_timer_t decay_timer_q;
	level_t       held_level_q;
	hold_count_t  hold_count_q;

	// input stage
	logic   valid_s1;
	level_t level_s1;

	// result register
	logic                result_valid_q;
	logic [MAX_LEDS-1:0] led_mask_q;
	level_t              shown_level_q;

	logic         advance;
	logic         level_take;
	level_t       level_clamped;
	logic         capture;
	logic         fire;
	logic signed [9:0] decayed;
	level_t       display_nxt;
	level_t       held_nxt;
	decay_timer_t timer_nxt;
	hold_count_t  count_loaded;
	hold_count_t  count_nxt;
	logic         peak_on;
	logic [4:0]   n_leds;
	logic [MAX_LEDS-1:0] bar_mask;
	logic [MAX_LEDS-1:0] top_mask;
	logic [MAX_LEDS-1:0] peak_mask;
	logic [MAX_LEDS-1:0] mask_nxt;

	// One-hot mask of the highest LED whose threshold -(n-k) the level meets, or zero if none
	function automatic logic [MAX_LEDS-1:0] top_led_mask(level_t lvl, logic [4:0] n);
		logic signed [10:0] t;
		logic [4:0]         idx;
		logic [MAX_LEDS-1:0] m;
		t = $signed({{2{lvl[8]}}, lvl}) + $signed({6'd0, n});
		idx = (t >= $signed({6'd0, n})) ? 5'(n - 5'd1) : t[4:0];
		m = '0;
		for (int k = 0; k < MAX_LEDS; k++) begin
			m[k] = (n != 5'd0) && (t >= 11'sd0) && (idx == 5'(k));
		end
		return m;
	endfunction

	// ------------------------------------------------------------------
	// Handshake: stage 1 moves on when the result register is free or drains
	// ------------------------------------------------------------------
	assign advance     = valid_s1 && (!result_valid_q || !result_stall);
	assign level_stall = valid_s1 && !advance;
	assign level_take  = level_valid && !level_stall;

	always_comb begin
		if (level_db < LEVEL_FLOOR) begin
			level_clamped = LEVEL_FLOOR;
		end else if (level_db > LEVEL_CEIL) begin
			level_clamped = LEVEL_CEIL;
		end else begin
			level_clamped = level_db;
		end
	end

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_step_q     <= RST_DECAY_STEP;
			decay_interval_q <= RST_DECAY_INTERVAL;
			hold_length_q    <= RST_HOLD_LENGTH;
			peak_hold_en_q   <= RST_PEAK_HOLD_EN;
			single_light_q   <= RST_SINGLE_LIGHT;
			led_count_q      <= RST_LED_COUNT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_DECAY_STEP:     decay_step_q     <= cfg_data[3:0];
				CFG_DECAY_INTERVAL: decay_interval_q <= cfg_data[7:0];
				CFG_HOLD_LENGTH:    hold_length_q    <= cfg_data[9:0];
				CFG_PEAK_HOLD_EN:   peak_hold_en_q   <= cfg_data[0];
				CFG_SINGLE_LIGHT:   single_light_q   <= cfg_data[0];
				CFG_LED_COUNT:      led_count_q      <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Update pass
	// ------------------------------------------------------------------
	assign n_leds = (led_count_q > 5'(MAX_LEDS)) ? 5'(MAX_LEDS) : led_count_q;

	always_comb begin
		capture = (level_s1 >= display_level_q) || (decay_step_q == 4'd0);
		fire    = decay_timer_q > {1'b0, decay_interval_q};
		decayed = $signed({display_level_q[8], display_level_q}) - $signed({6'd0, decay_step_q});

		if (capture) begin
			display_nxt  = level_s1;
			held_nxt     = level_s1;
			timer_nxt    = '0;
			count_loaded = hold_length_q;
		end else begin
			held_nxt     = held_level_q;
			count_loaded = hold_count_q;
			if (fire) begin
				timer_nxt   = '0;
				display_nxt = (decayed < $signed({LEVEL_FLOOR[8], LEVEL_FLOOR})) ?
					LEVEL_FLOOR : decayed[8:0];
			end else begin
				timer_nxt   = decay_timer_q + 9'd1;
				display_nxt = display_level_q;
			end
		end

		peak_on   = peak_hold_en_q && (count_loaded != '0);
		count_nxt = peak_on ? count_loaded - 10'd1 : count_loaded;
	end

	always_comb begin
		logic signed [10:0] t;
		t = $signed({{2{display_nxt[8]}}, display_nxt}) + $signed({6'd0, n_leds});
		for (int k = 0; k < MAX_LEDS; k++) begin
			bar_mask[k] = (5'(k) < n_leds) && (t >= $signed(11'(k)));
		end
		top_mask  = top_led_mask(display_nxt, n_leds);
		peak_mask = peak_on ? top_led_mask(held_nxt, n_leds) : '0;
		mask_nxt  = (single_light_q ? top_mask : bar_mask) | peak_mask;
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (level_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (level_take) begin
			level_s1 <= level_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_level_q <= '0;
			decay_timer_q   <= '0;
			held_level_q    <= '0;
			hold_count_q    <= '0;
			result_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				display_level_q <= display_nxt;
				decay_timer_q   <= timer_nxt;
				held_level_q    <= held_nxt;
				hold_count_q    <= count_nxt;
				result_valid_q  <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_mask_q    <= mask_nxt;
			shown_level_q <= display_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign led_mask     = led_mask_q;
	assign shown_level  = shown_level_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`LBM_ASSERT_IMPL(a_stall_only_when_blocked, level_stall, valid_s1 && result_valid_q && result_stall, "level stalled while result path free")
	`LBM_ASSERT_IMPL(a_timer_bound, 1'b1, decay_timer_q <= DECAY_TIMER_MAX, "decay timer out of range")
	`LBM_ASSERT_IMPL(a_display_range, 1'b1, (display_level_q >= LEVEL_FLOOR) && (display_level_q <= LEVEL_CEIL), "display level out of range")
	`LBM_ASSERT_NEXT(a_advance_gives_result, advance, result_valid_q, "transfer through stage 1 lost its result")

endmodule
